// File: hdl/text_console_cursor_engine_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text console cursor engine
// Both macros sample on the rising edge of clock and are off during reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH

// same-cycle implication
`define TCCE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCCE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared constants, codes and types of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

   // character store geometry
   localparam int STORE_ROWS  = 40;
   localparam int STORE_COLS  = 80;
   localparam int STORE_DEPTH = STORE_ROWS * STORE_COLS;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   // field widths
   localparam int ROW_W      = 6;
   localparam int COL_W      = 8;
   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int CELL_W     = CHAR_W + ATTR_W;
   localparam int KIND_W     = 3;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // request operations
   localparam logic [OP_W-1:0] OP_PUT        = 2'd0;
   localparam logic [OP_W-1:0] OP_READ       = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR      = 2'd2;
   localparam logic [OP_W-1:0] OP_SET_CURSOR = 2'd3;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_SERIAL = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DRAW   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SCROLL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DONE   = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_COLS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_ROWS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SEL_ENABLE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SEL_COL_A   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SEL_ROW_A   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SEL_COL_B   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SEL_ROW_B   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SILENT      = 3'd7;

   // register reset values
   localparam logic [COL_W-1:0] RESET_COLS = 8'd80;
   localparam logic [ROW_W-1:0] RESET_ROWS = 6'd20;

   // character codes
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;
   localparam logic [ATTR_W-1:0] BLANK_ATTR = 8'h07;

   // effective configuration, corners already sorted
   typedef struct packed {
      logic [COL_W-1:0] cols;
      logic [ROW_W-1:0] rows;
      logic             sel_enable;
      logic [COL_W-1:0] sel_col_lo;
      logic [COL_W-1:0] sel_col_hi;
      logic [ROW_W-1:0] sel_row_lo;
      logic [ROW_W-1:0] sel_row_hi;
      logic             silent;
   } cfg_type;

   // one write and one read access to the cell store
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [CELL_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

endpackage

// File: hdl/tcce_csr.sv
// ----------------------------------------------------------------------------
// tcce_csr
// Configuration registers; presents zero-safe screen size and sorted
// selection corners.
// ----------------------------------------------------------------------------
module tcce_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tcce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcce_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output tcce_pkg::cfg_type                cfg
);
   import tcce_pkg::*;

   logic [COL_W-1:0] cols_ff;
   logic [ROW_W-1:0] rows_ff;
   logic             sel_en_ff;
   logic [COL_W-1:0] col_a_ff;
   logic [ROW_W-1:0] row_a_ff;
   logic [COL_W-1:0] col_b_ff;
   logic [ROW_W-1:0] row_b_ff;
   logic             silent_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff   <= RESET_COLS;
         rows_ff   <= RESET_ROWS;
         sel_en_ff <= 1'b0;
         col_a_ff  <= '0;
         row_a_ff  <= '0;
         col_b_ff  <= '0;
         row_b_ff  <= '0;
         silent_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SCREEN_COLS: cols_ff   <= csr_wdata[COL_W-1:0];
            REG_SCREEN_ROWS: rows_ff   <= csr_wdata[ROW_W-1:0];
            REG_SEL_ENABLE:  sel_en_ff <= csr_wdata[0];
            REG_SEL_COL_A:   col_a_ff  <= csr_wdata[COL_W-1:0];
            REG_SEL_ROW_A:   row_a_ff  <= csr_wdata[ROW_W-1:0];
            REG_SEL_COL_B:   col_b_ff  <= csr_wdata[COL_W-1:0];
            REG_SEL_ROW_B:   row_b_ff  <= csr_wdata[ROW_W-1:0];
            REG_SILENT:      silent_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // zero size acts as one; corners sorted
   always_comb begin
      cfg.cols       = (cols_ff == '0) ? COL_W'(1) : cols_ff;
      cfg.rows       = (rows_ff == '0) ? ROW_W'(1) : rows_ff;
      cfg.sel_enable = sel_en_ff;
      cfg.sel_col_lo = (col_a_ff > col_b_ff) ? col_b_ff : col_a_ff;
      cfg.sel_col_hi = (col_a_ff > col_b_ff) ? col_a_ff : col_b_ff;
      cfg.sel_row_lo = (row_a_ff > row_b_ff) ? row_b_ff : row_a_ff;
      cfg.sel_row_hi = (row_a_ff > row_b_ff) ? row_a_ff : row_b_ff;
      cfg.silent     = silent_ff;
   end

endmodule

// File: hdl/tcce_store.sv
// ----------------------------------------------------------------------------
// tcce_store
// Character and attribute store: one write port, one read port with
// registered read data that holds until the next read.
// ----------------------------------------------------------------------------
module tcce_store (
   input  logic                          clock,
   input  tcce_pkg::mem_req_type         mem_req,
   output logic [tcce_pkg::CELL_W-1:0]   rdata
);
   import tcce_pkg::*;

   logic [CELL_W-1:0] cells_ff [STORE_DEPTH];
   logic [CELL_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         cells_ff[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rdata_ff <= cells_ff[mem_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text console engine: put character, read cell, clear and set cursor
// requests act on a cursor and a 40 x 80 character store, one request at a
// time under a small sequencer that drives one shared address and compare
// unit. Each response sits in an output register, and an emitting step
// waits while the previous response is still held. After reset the store
// is swept to zero before the first request is taken. A set cursor or read
// request passes through the request, a decode step and its response; a
// put passes through the request, the decode, each serial byte and the
// draw when there is one; a put that scrolls then moves the first
// min(screen_rows, 40) rows up through the store, and a clear runs its fill
// sweep; a stalled response channel adds its wait.
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_macros.svh"

module text_console_cursor_engine (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tcce_pkg::OP_W-1:0]        req_op,
   input  logic [tcce_pkg::CHAR_W-1:0]      req_ch,
   input  logic [tcce_pkg::ATTR_W-1:0]      req_attr,
   input  logic [tcce_pkg::ROW_W-1:0]       req_row,
   input  logic [tcce_pkg::COL_W-1:0]       req_col,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tcce_pkg::KIND_W-1:0]      rsp_kind,
   output logic [tcce_pkg::CHAR_W-1:0]      rsp_byte_value,
   output logic [tcce_pkg::ATTR_W-1:0]      rsp_attr_out,
   output logic [tcce_pkg::ROW_W-1:0]       rsp_out_row,
   output logic [tcce_pkg::COL_W-1:0]       rsp_out_col,
   output logic                             rsp_inverted,
   output logic                             rsp_stored,
   output logic                             rsp_last,
   // configuration
   input  logic                             csr_we,
   input  logic [tcce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcce_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tcce_pkg::*;

   localparam logic [3:0] S_INIT       = 4'd0;
   localparam logic [3:0] S_IDLE       = 4'd1;
   localparam logic [3:0] S_PREP       = 4'd2;
   localparam logic [3:0] S_ECHO       = 4'd3;
   localparam logic [3:0] S_DRAW       = 4'd4;
   localparam logic [3:0] S_SCROLL     = 4'd5;
   localparam logic [3:0] S_SCROLL_OUT = 4'd6;
   localparam logic [3:0] S_READ       = 4'd7;
   localparam logic [3:0] S_FILL       = 4'd8;
   localparam logic [3:0] S_DONE       = 4'd9;

   localparam int YW = ROW_W + 1;

   cfg_type           cfg;
   mem_req_type       mem_req;
   logic [CELL_W-1:0] rdata;

   // sequencer and request registers
   logic [3:0]        state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [1:0]        echo_cnt_ff, echo_cnt_in;
   logic [1:0]        echo_last_ff, echo_last_in;
   logic              has_draw_ff, has_draw_in;
   logic              has_scroll_ff, has_scroll_in;
   logic [COL_W-1:0]  draw_x_ff, draw_x_in;
   logic [YW-1:0]     draw_y_ff, draw_y_in;
   logic              draw_inv_ff, draw_inv_in;
   logic              draw_st_ff, draw_st_in;
   logic [ADDR_W-1:0] draw_addr_ff, draw_addr_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_dst_ff, pend_dst_in;
   logic [CNT_W-1:0]  copy_end_ff, copy_end_in;
   logic [CNT_W-1:0]  blank_end_ff, blank_end_in;

   // response registers
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [CHAR_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic [ATTR_W-1:0] rsp_attr_ff, rsp_attr_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic              rsp_inv_ff, rsp_inv_in;
   logic              rsp_st_ff, rsp_st_in;
   logic              rsp_last_ff, rsp_last_in;

   // put decode and shared cell unit
   logic              is_bs, is_nl, is_cr, is_tab, handled, act;
   logic [COL_W-1:0]  x0, dx, nx;
   logic [YW-1:0]     y0, dy, ny;
   logic              scroll;
   logic [ROW_W-1:0]  fin_row;
   logic [COL_W-1:0]  cx;
   logic [YW-1:0]     cy;
   logic              in_store, sel;
   logic [ADDR_W-1:0] cell_addr;
   logic [YW-1:0]     rows_cap;
   logic [CNT_W-1:0]  blank_end;
   logic [CNT_W-1:0]  src_idx;
   logic [CHAR_W-1:0] draw_ch;
   logic [CHAR_W-1:0] rd_ch;

   // emit path
   logic              out_free, emit;
   logic [KIND_W-1:0] e_kind;
   logic [CHAR_W-1:0] e_byte;
   logic [ATTR_W-1:0] e_attr;
   logic [ROW_W-1:0]  e_row;
   logic [COL_W-1:0]  e_col;
   logic              e_inv, e_st, e_last;

   tcce_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tcce_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   // character class of the latched request
   always_comb begin
      is_bs   = (ch_ff == CH_BS);
      is_nl   = (ch_ff == CH_NL);
      is_cr   = (ch_ff == CH_CR);
      is_tab  = (ch_ff == CH_TAB);
      handled = ((ch_ff >= CH_SPACE) && (ch_ff < CH_DEL)) || is_nl || is_cr || is_bs || is_tab;
      act     = handled && !cfg.silent;
   end

   // cursor movement for a put
   always_comb begin
      x0 = cur_col_ff;
      y0 = {1'b0, cur_row_ff};
      dx = x0;
      dy = y0;
      nx = x0;
      ny = y0;
      priority if (is_nl) begin
         nx = '0;
         ny = y0 + YW'(1);
      end else if (is_cr) begin
         nx = '0;
      end else if (is_bs) begin
         if (x0 != '0) begin
            dx = x0 - COL_W'(1);
         end else if (y0 != '0) begin
            dy = y0 - YW'(1);
            dx = cfg.cols - COL_W'(1);
         end
         nx = dx;
         ny = dy;
      end else begin
         // wrap when the cursor sits past the last column
         if (x0 >= cfg.cols) begin
            dx = '0;
            dy = y0 + YW'(1);
         end
         nx = dx + COL_W'(1);
         ny = dy;
      end
      scroll  = (ny >= {1'b0, cfg.rows});
      fin_row = scroll ? (cfg.rows - ROW_W'(1)) : ny[ROW_W-1:0];
   end

   // shared cell unit: bounds, selection and store address
   always_comb begin
      cx        = (op_ff == OP_READ) ? col_ff : dx;
      cy        = (op_ff == OP_READ) ? {1'b0, row_ff} : dy;
      in_store  = (cy < YW'(STORE_ROWS)) && (cx < COL_W'(STORE_COLS));
      sel       = cfg.sel_enable
                  && (cy >= {1'b0, cfg.sel_row_lo}) && (cy <= {1'b0, cfg.sel_row_hi})
                  && (cx >= cfg.sel_col_lo) && (cx <= cfg.sel_col_hi);
      cell_addr = ADDR_W'(cy) * ADDR_W'(STORE_COLS) + ADDR_W'(cx);
      rows_cap  = ({1'b0, cfg.rows} < YW'(STORE_ROWS)) ? {1'b0, cfg.rows} : YW'(STORE_ROWS);
      blank_end = CNT_W'(rows_cap) * CNT_W'(STORE_COLS);
   end

   // data seen by the emitting states
   always_comb begin
      src_idx  = idx_ff + CNT_W'(STORE_COLS);
      draw_ch  = is_bs ? CH_SPACE : ch_ff;
      rd_ch    = (rdata[CHAR_W-1:0] == '0) ? CH_SPACE : rdata[CHAR_W-1:0];
      out_free = !rsp_valid_ff || rsp_ready;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      ch_in         = ch_ff;
      attr_in       = attr_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      echo_cnt_in   = echo_cnt_ff;
      echo_last_in  = echo_last_ff;
      has_draw_in   = has_draw_ff;
      has_scroll_in = has_scroll_ff;
      draw_x_in     = draw_x_ff;
      draw_y_in     = draw_y_ff;
      draw_inv_in   = draw_inv_ff;
      draw_st_in    = draw_st_ff;
      draw_addr_in  = draw_addr_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      pend_dst_in   = pend_dst_ff;
      copy_end_in   = copy_end_ff;
      blank_end_in  = blank_end_ff;
      mem_req       = '0;
      emit          = 1'b0;
      e_kind        = KIND_SERIAL;
      e_byte        = '0;
      e_attr        = '0;
      e_row         = '0;
      e_col         = '0;
      e_inv         = 1'b0;
      e_st          = 1'b0;
      e_last        = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            // clearing pass after reset
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_ff[ADDR_W-1:0];
            mem_req.wdata = '0;
            idx_in        = idx_ff + CNT_W'(1);
            if (idx_ff == CNT_W'(STORE_DEPTH - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               ch_in    = req_ch;
               attr_in  = req_attr;
               row_in   = req_row;
               col_in   = req_col;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            echo_cnt_in   = '0;
            echo_last_in  = is_bs ? 2'd2 : 2'd0;
            has_draw_in   = (op_ff == OP_PUT) && act && !is_nl && !is_cr;
            has_scroll_in = (op_ff == OP_PUT) && act && scroll;
            draw_x_in     = cx;
            draw_y_in     = cy;
            draw_inv_in   = (op_ff == OP_READ) ? sel : (sel && !is_bs);
            draw_st_in    = in_store;
            draw_addr_in  = cell_addr;
            blank_end_in  = blank_end;
            copy_end_in   = blank_end - CNT_W'(STORE_COLS);
            idx_in        = '0;
            unique case (op_ff)
               OP_PUT: begin
                  if (act) begin
                     cur_col_in = nx;
                     cur_row_in = fin_row;
                  end
                  state_in = S_ECHO;
               end
               OP_READ: begin
                  mem_req.re    = in_store;
                  mem_req.raddr = cell_addr;
                  state_in      = S_READ;
               end
               OP_CLEAR: begin
                  cur_col_in = '0;
                  cur_row_in = '0;
                  state_in   = S_FILL;
               end
               OP_SET_CURSOR: begin
                  cur_col_in = col_ff;
                  cur_row_in = row_ff;
                  state_in   = S_DONE;
               end
            endcase
         end
         S_ECHO: begin
            // serial mirror, backspace goes out as BS SPACE BS
            if (out_free) begin
               emit   = 1'b1;
               e_kind = KIND_SERIAL;
               e_byte = is_bs ? ((echo_cnt_ff == 2'd1) ? CH_SPACE : CH_BS) : ch_ff;
               e_last = (echo_cnt_ff == echo_last_ff) && !has_draw_ff && !has_scroll_ff;
               if (echo_cnt_ff == echo_last_ff) begin
                  priority if (has_draw_ff) begin
                     state_in = S_DRAW;
                  end else if (has_scroll_ff) begin
                     state_in = S_SCROLL;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  echo_cnt_in = echo_cnt_ff + 2'd1;
               end
            end
         end
         S_DRAW: begin
            if (out_free) begin
               emit          = 1'b1;
               e_kind        = KIND_DRAW;
               e_byte        = draw_ch;
               e_attr        = attr_ff;
               e_row         = draw_y_ff[ROW_W-1:0];
               e_col         = draw_x_ff;
               e_inv         = draw_inv_ff;
               e_st          = draw_st_ff;
               e_last        = !has_scroll_ff;
               mem_req.we    = draw_st_ff;
               mem_req.waddr = draw_addr_ff;
               mem_req.wdata = {attr_ff, draw_ch};
               state_in      = has_scroll_ff ? S_SCROLL : S_IDLE;
            end
         end
         S_SCROLL: begin
            // copy row below into each row, then blank the new bottom row
            if (pend_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = pend_dst_ff;
               mem_req.wdata = rdata;
            end
            if (idx_ff < copy_end_ff) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = src_idx[ADDR_W-1:0];
               pend_in       = 1'b1;
               pend_dst_in   = idx_ff[ADDR_W-1:0];
               idx_in        = idx_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               if (idx_ff < blank_end_ff) begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = idx_ff[ADDR_W-1:0];
                  mem_req.wdata = {BLANK_ATTR, CH_SPACE};
                  idx_in        = idx_ff + CNT_W'(1);
               end else begin
                  state_in = S_SCROLL_OUT;
               end
            end
         end
         S_SCROLL_OUT: begin
            if (out_free) begin
               emit     = 1'b1;
               e_kind   = KIND_SCROLL;
               e_last   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            if (out_free) begin
               emit     = 1'b1;
               e_kind   = KIND_READ;
               e_byte   = draw_st_ff ? rd_ch : CH_SPACE;
               e_attr   = draw_st_ff ? rdata[CELL_W-1:CHAR_W] : '0;
               e_row    = draw_y_ff[ROW_W-1:0];
               e_col    = draw_x_ff;
               e_inv    = draw_inv_ff;
               e_last   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FILL: begin
            // clear sweep with blank cells
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_ff[ADDR_W-1:0];
            mem_req.wdata = {BLANK_ATTR, CH_SPACE};
            idx_in        = idx_ff + CNT_W'(1);
            if (idx_ff == CNT_W'(STORE_DEPTH - 1)) begin
               idx_in   = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               e_kind   = KIND_DONE;
               e_last   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response register next values
   always_comb begin
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
      rsp_kind_in  = emit ? e_kind : rsp_kind_ff;
      rsp_byte_in  = emit ? e_byte : rsp_byte_ff;
      rsp_attr_in  = emit ? e_attr : rsp_attr_ff;
      rsp_row_in   = emit ? e_row  : rsp_row_ff;
      rsp_col_in   = emit ? e_col  : rsp_col_ff;
      rsp_inv_in   = emit ? e_inv  : rsp_inv_ff;
      rsp_st_in    = emit ? e_st   : rsp_st_ff;
      rsp_last_in  = emit ? e_last : rsp_last_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      ch_ff         <= ch_in;
      attr_ff       <= attr_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      echo_cnt_ff   <= echo_cnt_in;
      echo_last_ff  <= echo_last_in;
      has_draw_ff   <= has_draw_in;
      has_scroll_ff <= has_scroll_in;
      draw_x_ff     <= draw_x_in;
      draw_y_ff     <= draw_y_in;
      draw_inv_ff   <= draw_inv_in;
      draw_st_ff    <= draw_st_in;
      draw_addr_ff  <= draw_addr_in;
      pend_dst_ff   <= pend_dst_in;
      copy_end_ff   <= copy_end_in;
      blank_end_ff  <= blank_end_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_attr_ff   <= rsp_attr_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_inv_ff    <= rsp_inv_in;
      rsp_st_ff     <= rsp_st_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_byte_value = rsp_byte_ff;
   assign rsp_attr_out   = rsp_attr_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_inverted   = rsp_inv_ff;
   assign rsp_stored     = rsp_st_ff;
   assign rsp_last       = rsp_last_ff;

   // checks
   `TCCE_ASSERT_IMP(a_emit_slot_free, emit, !rsp_valid_ff || rsp_ready, "response overwritten")
   `TCCE_ASSERT_IMP(a_idle_no_write, state_ff == S_IDLE, !mem_req.we, "store written while idle")
   `TCCE_ASSERT_IMP(a_pend_in_scroll, pend_ff, state_ff == S_SCROLL, "copy write outside scroll")
   `TCCE_ASSERT_IMP(a_sweep_bound, state_ff == S_SCROLL, idx_ff <= blank_end_ff, "scroll overrun")
   `TCCE_ASSERT_NXT(a_accept_prep, req_valid && req_ready, state_ff == S_PREP, "request lost")

endmodule
